// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

    localparam int unsigned OpWidth   = 32;
    localparam int unsigned ProdWidth = 2 * OpWidth;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MC_P  = 2'd0,
        MC_Q  = 2'd1,
        MC_NM = 2'd2,
        MC_DN = 2'd3
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MUL_WAIT,
        S_SUM,
        S_GCD_SHIFT,
        S_GCD_STEP,
        S_GCD_DONE,
        S_DIV_NUM,
        S_DIV_DEN,
        S_PACK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

// ===== hw/rtl/rau_if.sv =====
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
    logic        a_less;
    logic        a_equal;
    logic        a_greater;
    modport source (output valid, res_num, res_den, status, a_less, a_equal, a_greater,
                    input ready);
    modport sink   (input valid, res_num, res_den, status, a_less, a_equal, a_greater,
                    output ready);
endinterface

// ===== hw/rtl/rau_divider.sv =====
// restoring divider, one quotient bit per cycle
module rau_divider #(
    parameter int unsigned WIDTH = rau_pkg::ProdWidth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDTH-1:0]  i_dividend,
    input  logic [WIDTH-1:0]  i_divisor,
    output rau_pkg::t_div_ctl o_ctl,
    output logic [WIDTH-1:0]  o_quot
);
    import rau_pkg::*;

    localparam int unsigned CntWidth = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]    r_quot, n_quot;
    logic [WIDTH-1:0]    r_rem, n_rem;
    logic [WIDTH-1:0]    r_dvs;
    logic [CntWidth-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [WIDTH:0]      w_trial;

    always_comb begin
        w_trial = {r_rem, r_quot[WIDTH-1]};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = CntWidth'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem  = WIDTH'(w_trial - {1'b0, r_dvs});
                n_quot = {r_quot[WIDTH-2:0], 1'b1};
            end else begin
                n_rem  = w_trial[WIDTH-1:0];
                n_quot = {r_quot[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntWidth'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_quot;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |-> (r_cnt != '0)) else $error("busy with zero count");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
`endif

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | operation, a_num, a_den, b_num, b_den
// o_out   | out | valid / ready | res_num, res_den, status, a_less, a_equal, a_greater
//
// one transaction at a time; ready is high only in idle
// sequence: 4 multiplies, sum, binary gcd of 64-bit values (steps of the
//   shared subtract/shift unit) and two 64-bit divisions
// the shared 64-bit restoring divider performs both divisions
// a zero input denominator skips the arithmetic: result valid the cycle after accept
// reset is synchronous and active low, and clears the sequencer and valid
// a result waits in the output register until taken; no new transaction meanwhile
module rational_arithmetic_unit #(
    parameter int unsigned OPERAND_WIDTH = rau_pkg::OpWidth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    localparam int unsigned PW = 2 * OPERAND_WIDTH;
    localparam int unsigned GcW = $clog2(PW + 1);

    t_state r_state, n_state;

    // sign-magnitude operands, signs already moved into numerators
    logic [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic                     r_an_neg, r_bn_neg;
    t_op                      r_op;
    logic [1:0]               r_mcnt;
    logic [PW-1:0]            r_p, r_q, r_nm, r_dn;
    logic [PW-1:0]            r_num, r_den, r_gx, r_gy;
    logic                     r_num_neg;
    logic [GcW-1:0]           r_shift;
    logic [PW-1:0]            r_g;
    logic [PW-1:0]            r_qn;
    logic [31:0]              r_res_num;
    logic [30:0]              r_res_den;
    t_status                  r_status;
    logic                     r_lt, r_eq, r_gt, r_valid;

    // input magnitudes
    function automatic logic [OPERAND_WIDTH-1:0] f_mag(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] x;
        x = v[OPERAND_WIDTH-1:0];
        return x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

    logic [OPERAND_WIDTH-1:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = f_mag(i_in.a_num);
    assign w_ad = f_mag(i_in.a_den);
    assign w_bn = f_mag(i_in.b_num);
    assign w_bd = f_mag(i_in.b_den);

    // shared multiplier, operand pair chosen by the step counter
    logic [OPERAND_WIDTH-1:0] w_mx, w_my;
    logic [PW-1:0]            r_mprod;
    always_comb begin
        unique case (t_mul_sel'(r_mcnt))
            MC_P:    begin w_mx = r_an; w_my = r_bd; end
            MC_Q:    begin w_mx = r_bn; w_my = r_ad; end
            MC_NM:   begin w_mx = r_an; w_my = (r_op == OP_DIV) ? r_bd : r_bn; end
            default: begin w_mx = r_ad; w_my = (r_op == OP_DIV) ? r_bn : r_bd; end
        endcase
    end

    // signed sum of p and q, q negated for subtract and for the compare
    logic          w_q_neg_add, w_q_neg_cmp, w_p_neg;
    logic [PW-1:0] w_mag;
    logic          w_sneg;
    logic [PW-1:0] w_cmag;
    logic          w_cneg;
    assign w_p_neg     = (r_p != '0) && r_an_neg;
    assign w_q_neg_add = (r_q != '0) && (r_bn_neg ^ (r_op == OP_SUB));
    assign w_q_neg_cmp = (r_q != '0) && !r_bn_neg;

    function automatic logic [PW:0] f_add(input logic [PW-1:0] x, input logic xn,
                                          input logic [PW-1:0] y, input logic yn);
        logic [PW-1:0] m;
        logic          s;
        if (xn == yn) begin
            m = x + y; s = xn;
        end else if (x >= y) begin
            m = x - y; s = xn;
        end else begin
            m = y - x; s = yn;
        end
        return {s && (m != '0), m};
    endfunction

    assign {w_sneg, w_mag}  = f_add(r_p, w_p_neg, r_q, w_q_neg_add);
    assign {w_cneg, w_cmag} = f_add(r_p, w_p_neg, r_q, w_q_neg_cmp);

    // shared divider
    t_div_ctl      w_dctl;
    logic          w_dstart;
    logic [PW-1:0] w_dvd;
    logic [PW-1:0] w_quot;
    logic [PW-1:0] w_gcd;
    logic [PW-1:0] w_dvs;

    // divisor is the fresh gcd on the first start, held in r_g afterwards
    assign w_gcd = (r_gx | r_gy) << r_shift;
    assign w_dvd = (r_state == S_GCD_DONE) ? r_num : r_den;
    assign w_dvs = (r_state == S_GCD_DONE) ? w_gcd : r_g;

    rau_divider #(
        .WIDTH (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_ctl      (w_dctl),
        .o_quot     (w_quot)
    );

    logic w_in_acc, w_zero_den;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_zero_den = (w_ad == '0) || (w_bd == '0);
    assign i_in.ready = (r_state == S_IDLE);

    // fit check of the reduced pair
    localparam logic [PW-1:0] Half = PW'(1) << (OPERAND_WIDTH - 1);
    logic w_fits;
    assign w_fits = (r_g <= Half - 1'b1) &&
                    (r_num_neg ? (r_qn <= Half) : (r_qn <= Half - 1'b1));

    always_comb begin
        n_state  = r_state;
        w_dstart = 1'b0;
        unique case (r_state)
            // zero denominator result is ready at once, straight to the output
            S_IDLE:      if (w_in_acc) n_state = w_zero_den ? S_OUT : S_MUL;
            S_MUL:       n_state = S_MUL_WAIT;
            S_MUL_WAIT:  if (r_mcnt == 2'd0) n_state = S_SUM; else n_state = S_MUL;
            S_SUM:       n_state = S_GCD_SHIFT;
            // binary gcd: strip common twos, then subtract and shift
            S_GCD_SHIFT: if (r_gx[0] || r_gy[0] || r_gx == '0) n_state = S_GCD_STEP;
            S_GCD_STEP:  if (r_gy == '0 || r_gx == '0) n_state = S_GCD_DONE;
            S_GCD_DONE: begin
                w_dstart = 1'b1;
                n_state  = S_DIV_NUM;
            end
            S_DIV_NUM:   if (w_dctl.done) begin
                w_dstart = 1'b1;
                n_state  = S_DIV_DEN;
            end
            S_DIV_DEN:   if (w_dctl.done) n_state = S_PACK;
            S_PACK:      n_state = S_OUT;
            S_OUT:       if (o_out.ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_in_acc && w_zero_den) begin
                r_valid <= 1'b1;
            end else if (r_state == S_PACK) begin
                r_valid <= 1'b1;
            end else if (r_valid && o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_mcnt <= '0;
            end else if (r_state == S_MUL) begin
                r_mcnt <= r_mcnt + 1'b1;
            end
        end

        if (r_state == S_IDLE && w_in_acc) begin
            r_op     <= t_op'(i_in.operation);
            r_an     <= w_an;
            r_ad     <= w_ad;
            r_bn     <= w_bn;
            r_bd     <= w_bd;
            r_an_neg <= (w_an != '0) &&
                        (i_in.a_num[OPERAND_WIDTH-1] ^ i_in.a_den[OPERAND_WIDTH-1]);
            r_bn_neg <= (w_bn != '0) &&
                        (i_in.b_num[OPERAND_WIDTH-1] ^ i_in.b_den[OPERAND_WIDTH-1]);
            if (w_zero_den) begin
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_status  <= ST_ZERO_DEN;
                r_lt <= 1'b0; r_eq <= 1'b0; r_gt <= 1'b0;
            end
        end

        if (r_state == S_MUL) begin
            r_mprod <= w_mx * w_my;
        end
        if (r_state == S_MUL_WAIT) begin
            unique case (t_mul_sel'(r_mcnt - 1'b1))
                MC_P:    r_p  <= r_mprod;
                MC_Q:    r_q  <= r_mprod;
                MC_NM:   r_nm <= r_mprod;
                default: r_dn <= r_mprod;
            endcase
        end

        if (r_state == S_SUM) begin
            r_lt <= w_cneg;
            r_eq <= (w_cmag == '0);
            r_gt <= !w_cneg && (w_cmag != '0);
            if (r_op == OP_ADD || r_op == OP_SUB) begin
                r_num     <= w_mag;
                r_num_neg <= w_sneg;
                r_gx      <= w_mag;
            end else begin
                r_num     <= r_nm;
                r_num_neg <= (r_nm != '0) && (r_an_neg ^ r_bn_neg);
                r_gx      <= r_nm;
            end
            r_den   <= r_dn;
            r_gy    <= r_dn;
            r_shift <= '0;
        end

        if (r_state == S_GCD_SHIFT && !(r_gx[0] || r_gy[0] || r_gx == '0)) begin
            r_gx    <= r_gx >> 1;
            r_gy    <= r_gy >> 1;
            r_shift <= r_shift + 1'b1;
        end
        if (r_state == S_GCD_STEP && r_gx != '0 && r_gy != '0) begin
            if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= (r_gx - r_gy) >> 1;
            end else begin
                r_gy <= (r_gy - r_gx) >> 1;
            end
        end
        if (r_state == S_GCD_DONE) begin
            r_g <= w_gcd;
        end
        if (r_state == S_DIV_NUM && w_dctl.done) begin
            r_qn <= w_quot;
        end
        if (r_state == S_DIV_DEN && w_dctl.done) begin
            r_g <= w_quot;
        end

        if (r_state == S_PACK) begin
            if (r_op == OP_DIV && r_bn == '0) begin
                r_status  <= ST_DIV_ZERO;
                r_res_num <= '0;
                r_res_den <= 31'd1;
            end else if (r_num == '0) begin
                r_status  <= ST_OK;
                r_res_num <= '0;
                r_res_den <= 31'd1;
            end else if (!w_fits) begin
                r_status  <= ST_OVERFLOW;
                r_res_num <= '0;
                r_res_den <= 31'd1;
            end else begin
                r_status  <= ST_OK;
                r_res_num <= r_num_neg ? (32'd0 - 32'(r_qn)) : 32'(r_qn);
                r_res_den <= 31'(r_g);
            end
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.res_num   = r_res_num;
    assign o_out.res_den   = r_res_den;
    assign o_out.status    = r_status;
    assign o_out.a_less    = r_lt;
    assign o_out.a_equal   = r_eq;
    assign o_out.a_greater = r_gt;

`ifndef SYNTH
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_ZERO_DEN) |-> $onehot({r_lt, r_eq, r_gt}))
        else $error("order flags not one-hot");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_state == S_MUL || r_state == S_GCD_STEP))
        else $error("result held while busy");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res_den != '0)) else $error("zero result denominator");
`endif

endmodule
